// ===== design/lsp_pkg.sv =====
package lsp_pkg;

    localparam int CoordBits = 16;
    localparam int DiffBits  = CoordBits + 1;
    localparam int TermBits  = CoordBits + 3;

    localparam logic OpStart   = 1'b0;
    localparam logic OpAdvance = 1'b1;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [DiffBits-1:0]  t_diff;
    typedef logic        [CoordBits-1:0] t_mag;
    typedef logic signed [TermBits-1:0]  t_term;

    typedef struct packed {
        logic   op;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } t_rsp;

endpackage

// ===== design/line_pixel_stepper.sv =====
// Channel   | direction | valid        | ready        | payload
// ----------+-----------+--------------+--------------+---------------------------
// request   | in        | i_req_valid  | o_req_ready  | i_req (op and endpoints)
// response  | out       | o_rsp_valid  | i_rsp_ready  | o_rsp (pixel and flags)
//
// One request enters per clock while the response slot is free or draining, and
// yields exactly one response; the stepping datapath between the request and
// response registers is a single pass, so sustained rate is one pixel per cycle.
// An accepted request is held in the request register and moves into the response
// register, which drives the response, as soon as that register is free or draining.
// Reset (synchronous, active low) empties both registers and drops any active line.
// A stalled response holds the response register and stops the request register
// from draining; the request side keeps taking a request while that slot is free.
module line_pixel_stepper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  lsp_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output lsp_pkg::t_rsp o_rsp
);
    import lsp_pkg::*;

    // Request register
    logic   r_req_valid;
    t_req   r_req;

    // Response register
    logic   r_rsp_valid;
    t_rsp   r_rsp;
    t_rsp   n_rsp;

    // Line state: the last pixel given out, in original coordinates, plus the
    // stepping direction and the Bresenham decision term for the next pixel.
    logic   r_active,  n_active;
    t_coord r_x,       n_x;
    t_coord r_y,       n_y;
    t_coord r_end,     n_end;     // end coordinate along the major axis
    logic   r_ymajor,  n_ymajor;  // y is the major axis
    logic   r_xneg,    n_xneg;    // x moves toward smaller values
    logic   r_yneg,    n_yneg;    // y moves toward smaller values
    t_term  r_term,    n_term;
    t_term  r_diag,    n_diag;    // term increment when the minor axis steps
    t_term  r_axis,    n_axis;    // term increment when it does not

    logic   move;

    // Start-of-line setup
    t_diff  dx, dy;
    t_mag   adx, ady, maj_d, min_d;
    logic   st_ymajor, st_vert, st_horz, st_equal, swap_v, swap_h;
    t_coord sp_x, sp_y, st_end;
    t_term  st_term, st_diag, st_axis;

    // Advance step
    logic   minor_step, x_move, y_move, adv_last;
    t_coord x_delta, y_delta, x_next, y_next;
    t_term  term_next;

    // A request moves into the response register when that slot is free or
    // being emptied this cycle.
    assign move        = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || move;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Setup: deltas, octant class, first pixel and decision term.
    always_comb begin
        dx = t_diff'(r_req.end_x) - t_diff'(r_req.start_x);
        dy = t_diff'(r_req.end_y) - t_diff'(r_req.start_y);
        adx = dx[DiffBits-1] ? t_mag'(-dx) : dx[CoordBits-1:0];
        ady = dy[DiffBits-1] ? t_mag'(-dy) : dy[CoordBits-1:0];
        st_vert   = (dx == '0);
        st_horz   = (dy == '0);
        st_equal  = st_vert && st_horz;
        // Ties on |dx| = |dy| keep x as the major axis.
        st_ymajor = (ady > adx);
        // Axis-aligned lines run from the smaller coordinate: swap endpoints.
        swap_v = st_vert && dy[DiffBits-1];
        swap_h = st_horz && dx[DiffBits-1];
        sp_x   = swap_h ? r_req.end_x : r_req.start_x;
        sp_y   = swap_v ? r_req.end_y : r_req.start_y;
        if (st_ymajor) begin
            st_end = swap_v ? r_req.start_y : r_req.end_y;
            maj_d  = ady;
            min_d  = adx;
        end else begin
            st_end = swap_h ? r_req.start_x : r_req.end_x;
            maj_d  = adx;
            min_d  = ady;
        end
        st_axis = t_term'({min_d, 1'b0});
        st_term = st_axis - t_term'(maj_d);
        st_diag = st_axis - t_term'({maj_d, 1'b0});
    end

    // Advance: step the major axis, step the minor axis on a positive term.
    always_comb begin
        minor_step = !r_term[TermBits-1] && (r_term != '0);
        x_move     = r_ymajor ? minor_step : 1'b1;
        y_move     = r_ymajor ? 1'b1 : minor_step;
        x_delta    = x_move ? (r_xneg ? '1 : t_coord'(1)) : '0;
        y_delta    = y_move ? (r_yneg ? '1 : t_coord'(1)) : '0;
        x_next     = r_x + x_delta;
        y_next     = r_y + y_delta;
        adv_last   = ((r_ymajor ? y_next : x_next) == r_end);
        term_next  = r_term + (minor_step ? r_diag : r_axis);
    end

    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_end    = r_end;
        n_ymajor = r_ymajor;
        n_xneg   = r_xneg;
        n_yneg   = r_yneg;
        n_term   = r_term;
        n_diag   = r_diag;
        n_axis   = r_axis;
        n_rsp    = '0;
        case (r_req.op)
            OpStart: begin
                // Drop any line; first pixel: start, or low end if axis-aligned.
                n_rsp.pixel_x     = sp_x;
                n_rsp.pixel_y     = sp_y;
                n_rsp.pixel_valid = 1'b1;
                n_rsp.last_pixel  = st_equal;
                n_active = !st_equal;
                n_x      = sp_x;
                n_y      = sp_y;
                n_end    = st_end;
                n_ymajor = st_ymajor;
                n_xneg   = dx[DiffBits-1] && !st_horz;
                n_yneg   = dy[DiffBits-1] && !st_vert;
                n_term   = st_term;
                n_diag   = st_diag;
                n_axis   = st_axis;
            end
            OpAdvance: begin
                // With no line active, answer with an invalid all-zero pixel.
                if (r_active) begin
                    n_rsp.pixel_x     = x_next;
                    n_rsp.pixel_y     = y_next;
                    n_rsp.pixel_valid = 1'b1;
                    n_rsp.last_pixel  = adv_last;
                    n_active = !adv_last;
                    n_x      = x_next;
                    n_y      = y_next;
                    n_term   = term_next;
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_req_valid <= i_req_valid;
            end
            if (move) begin
                r_rsp_valid <= 1'b1;
                r_active    <= n_active;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload and line datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
        if (move) begin
            r_rsp    <= n_rsp;
            r_x      <= n_x;
            r_y      <= n_y;
            r_end    <= n_end;
            r_ymajor <= n_ymajor;
            r_xneg   <= n_xneg;
            r_yneg   <= n_yneg;
            r_term   <= n_term;
            r_diag   <= n_diag;
            r_axis   <= n_axis;
        end
    end

`ifndef SYNTH
    // An invalid response never claims to end a line.
    a_invalid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !r_rsp.pixel_valid) |-> (!r_rsp.last_pixel && r_rsp.pixel_x == '0
            && r_rsp.pixel_y == '0))
        else $error("invalid response carries pixel data");

    // The final pixel of a line leaves no line active.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_rsp.last_pixel) |=> !r_active)
        else $error("line still active after its last pixel");

    // An advance on an active line always yields a pixel.
    a_advance_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_req.op == OpAdvance && r_active) |=> (r_rsp_valid && r_rsp.pixel_valid))
        else $error("advance on active line gave no pixel");

    // The diagonal increment never raises the term; the axial one never lowers it.
    a_term_incr_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (!r_axis[TermBits-1] && (r_diag[TermBits-1] || r_diag == '0)))
        else $error("decision term increments out of range");
`endif

endmodule
